FILE: rtl/tom_pkg.sv
`default_nettype none
package tom_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = 8;

    localparam int DVD_W = 42;
    localparam int DVS_W = 39;
    localparam int DCNT_W = 6;

    localparam logic [2:0] REG_POLICY = 3'd0;
    localparam logic [2:0] REG_GRACE = 3'd1;
    localparam logic [2:0] REG_GRACE_DIV = 3'd2;
    localparam logic [2:0] REG_SAFETY = 3'd3;
    localparam logic [2:0] REG_OFF_LIMIT = 3'd4;
    localparam logic [2:0] REG_STRETCH = 3'd5;
    localparam logic [2:0] REG_SLIP = 3'd6;
    localparam logic [2:0] REG_TICK = 3'd7;

    localparam logic [2:0] POL_NOTHING = 3'd0;
    localparam logic [2:0] POL_RESYNC = 3'd1;
    localparam logic [2:0] POL_DEBUG = 3'd2;
    localparam logic [2:0] POL_STRETCH = 3'd3;
    localparam logic [2:0] POL_SLIP = 3'd4;
    localparam logic [2:0] POL_SUSPEND = 3'd5;
    localparam logic [2:0] POL_KILL = 3'd6;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_RESYNC = 3'd1;
    localparam logic [2:0] ACT_STRETCH = 3'd2;
    localparam logic [2:0] ACT_SUSPEND = 3'd3;
    localparam logic [2:0] ACT_KILL = 3'd4;
    localparam logic [2:0] ACT_RESUME = 3'd5;
    localparam logic [2:0] ACT_WARN = 3'd6;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] count;
        logic [31:0] orig;
        logic        slipping;
        logic [31:0] countdown;
        logic        forced;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic             seen_en;
        logic [IDX_W-1:0] seen_addr;
        logic             alloc_en;
        logic             purge;
    } t_tbl_ctl;

endpackage
`default_nettype wire

FILE: rtl/task_overrun_policy_monitor.sv
// Task overrun policy monitor.
// Input words arrive on the s_axis channel, one per task observation; tuser
// set marks a tick end word that purges entries not seen during the tick.
// Every input word gives exactly one output word on m_axis.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; they are to be written only while the block is idle, which
// the block itself does not enforce. One item is processed at a time.
// The offender table is searched one entry per cycle through the table
// memory. A slip decision then runs the bit-serial divider; a stretch
// decision adds reciprocal multiply steps.
// The result waits in an output register; s_axis_tready returns once it is
// loaded, so the next word is taken while the result is still unclaimed.
// A stalled receiver holds the block only when a second result is ready.
// Reset clears the table's used and seen bits and restores the register
// defaults; no clearing pass is needed.
`default_nettype none
module task_overrun_policy_monitor #(
    parameter int TABLE_ENTRIES = tom_pkg::TABLE_ENTRIES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // task_id, period, elapsed, resync_pending, blocked, other_watchdog
    input  wire logic [79:0] s_axis_tdata,
    // mode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // task_out, action, new_period, forced, offence_count, table_full
    output logic [63:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import tom_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_DEC = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_FIN = 3'd5;
    localparam logic [2:0] S_STR = 3'd6;

    localparam logic [31:0] OQ_RECIP = 32'd2748779070;
    localparam logic [17:0] FRAC_RECIP = 18'd167773;

    logic [2:0]  r_state;
    logic [2:0]  r_policy;
    logic [7:0]  r_grace;
    logic [7:0]  r_grace_div;
    logic [10:0] r_safety;
    logic [16:0] r_off_limit;
    logic [9:0]  r_stretch;
    logic [9:0]  r_slip;
    logic [31:0] r_tick;

    logic [7:0]  r_tid;
    logic [31:0] r_period;
    logic [31:0] r_elapsed;
    logic        r_resync;
    logic        r_blocked;
    logic        r_other;

    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_raddr;
    logic          r_rv;
    logic          r_hit;
    logic [AW-1:0] r_idx;
    t_entry        r_ent;

    logic [39:0] r_pa;
    logic [40:0] r_pb;
    logic [41:0] r_ps;
    logic [41:0] r_psl;
    logic [38:0] r_tp100;

    logic [25:0] r_oq;
    logic [6:0]  r_orem;
    logic [35:0] r_oqs;
    logic [16:0] r_rs;
    logic [9:0]  r_frac;
    logic [1:0]  r_step;

    logic [2:0]       r_act;
    logic [31:0]      r_newp;
    logic             r_forced;
    logic [15:0]      r_cnt;
    logic             r_full;
    t_entry           r_went;
    logic [IDX_W-1:0] r_widx;
    logic             r_div_start;

    logic        r_ovalid;
    logic [63:0] r_odata;

    t_tbl_ctl         ctl;
    t_entry           tbl_data;
    logic             tbl_used;
    logic [IDX_W-1:0] free_idx;
    logic             free_ok;
    logic             div_done;
    logic [DVD_W-1:0] div_quot;

    logic             accept;
    logic             hit_now;
    logic [31:0]      orig_sel;
    logic [7:0]       g;
    logic [7:0]       gd;

    logic [2:0]       d_act;
    logic             d_forced;
    logic [15:0]      d_cnt;
    logic             d_full;
    logic             d_write;
    logic             d_alloc;
    logic             d_div;
    logic             d_str;
    t_entry           d_ent;
    logic [IDX_W-1:0] d_widx;
    logic             dbg;
    logic             offence;
    logic [15:0]      cnt_inc;
    logic [63:0]      oq_prod;
    logic [31:0]      orem_full;
    logic [34:0]      frac_prod;
    logic [36:0]      newp_sum;

    tom_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .o_rd_data (tbl_data),
        .o_rd_used (tbl_used),
        .o_free_idx(free_idx),
        .o_free_ok (free_ok)
    );

    tom_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_dvd  (r_psl),
        .i_dvs  (r_tp100),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_SUSPEND;
            r_grace <= 8'd3;
            r_grace_div <= 8'd1;
            r_safety <= 11'd100;
            r_off_limit <= 17'd100;
            r_stretch <= 10'd10;
            r_slip <= 10'd10;
            r_tick <= 32'd10000000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POLICY: r_policy <= i_cfg_data[2:0];
                REG_GRACE: r_grace <= i_cfg_data[7:0];
                REG_GRACE_DIV: r_grace_div <= i_cfg_data[7:0];
                REG_SAFETY: r_safety <= i_cfg_data[10:0];
                REG_OFF_LIMIT: r_off_limit <= i_cfg_data[16:0];
                REG_STRETCH: r_stretch <= i_cfg_data[9:0];
                REG_SLIP: r_slip <= i_cfg_data[9:0];
                REG_TICK: r_tick <= i_cfg_data;
                default: r_tick <= r_tick;
            endcase
        end
    end

    assign hit_now = r_rv && tbl_used && (tbl_data.task_id == r_tid);
    assign orig_sel = r_hit ? r_ent.orig : r_period;
    assign g = (r_policy <= POL_STRETCH) ? 8'd1 : r_grace;
    assign gd = ((r_policy <= POL_STRETCH) || (r_grace_div == '0)) ? 8'd1 : r_grace_div;

    always_comb begin
        dbg = (r_policy == POL_DEBUG);
        offence = {1'b0, r_pa} < r_pb;
        d_act = ACT_NONE;
        d_forced = 1'b0;
        d_cnt = r_hit ? r_ent.count : 16'd0;
        d_full = 1'b0;
        d_write = 1'b0;
        d_alloc = 1'b0;
        d_div = 1'b0;
        d_str = 1'b0;
        d_widx = r_hit ? IDX_W'(r_idx) : free_idx;
        d_ent = r_ent;
        cnt_inc = 16'd0;
        if (r_hit && r_ent.slipping) begin
            d_write = 1'b1;
            if (r_ent.countdown <= 32'd1) begin
                d_ent.countdown = 32'd0;
                d_ent.slipping = 1'b0;
                d_act = ACT_RESUME;
            end else begin
                d_ent.countdown = r_ent.countdown - 32'd1;
            end
        end else if (r_period != '0 && !r_resync && !r_blocked && offence) begin
            if (r_other) begin
                d_act = ACT_WARN;
            end else if (!r_hit && !free_ok) begin
                d_full = 1'b1;
            end else begin
                if (!r_hit) begin
                    d_alloc = 1'b1;
                    d_ent.task_id = r_tid;
                    d_ent.count = 16'd0;
                    d_ent.orig = r_period;
                    d_ent.slipping = 1'b0;
                    d_ent.countdown = 32'd0;
                    d_ent.forced = 1'b0;
                end
                cnt_inc = (d_ent.count != 16'hFFFF) ? d_ent.count + 16'd1 : d_ent.count;
                d_ent.count = cnt_inc;
                d_cnt = cnt_inc;
                d_write = 1'b1;
                if (!dbg && !r_safety[10] && ({10'd0, r_elapsed} >= r_ps)) begin
                    d_ent.forced = 1'b1;
                    d_forced = 1'b1;
                    d_act = ACT_SUSPEND;
                end else if (!dbg && !r_off_limit[16] &&
                             ($signed({1'b0, cnt_inc}) >= $signed(r_off_limit))) begin
                    d_ent.forced = 1'b1;
                    d_forced = 1'b1;
                    d_act = ACT_SUSPEND;
                end else begin
                    case (r_policy)
                        POL_RESYNC, POL_DEBUG: d_act = ACT_RESYNC;
                        POL_STRETCH: begin
                            d_act = ACT_STRETCH;
                            d_str = 1'b1;
                        end
                        POL_SLIP: begin
                            d_act = ACT_SUSPEND;
                            d_ent.slipping = 1'b1;
                            d_div = 1'b1;
                        end
                        POL_SUSPEND: d_act = ACT_SUSPEND;
                        POL_KILL: d_act = ACT_KILL;
                        default: d_act = ACT_NONE;
                    endcase
                end
            end
        end
    end

    // The stretch amount orig * pct / 100 is split as (orig / 100) * pct plus
    // ((orig % 100) * pct) / 100, each quotient taken by a reciprocal multiply.
    assign oq_prod = 64'(orig_sel) * 64'(OQ_RECIP);
    assign orem_full = orig_sel - (32'(r_oq) * 32'd100);
    assign frac_prod = 35'(r_rs) * 35'(FRAC_RECIP);
    assign newp_sum = 37'(r_period) + 37'(r_oqs) + 37'(r_frac);

    always_comb begin
        ctl = '0;
        ctl.rd_addr = IDX_W'(r_addr);
        ctl.wr_addr = r_widx;
        ctl.wr_data = r_went;
        ctl.seen_addr = IDX_W'(r_idx);
        ctl.purge = accept && s_axis_tuser;
        if (r_state == S_DEC) begin
            ctl.wr_en = d_write && !d_div && !d_str;
            ctl.wr_addr = d_widx;
            ctl.wr_data = d_ent;
            ctl.seen_en = r_hit;
            ctl.alloc_en = d_alloc;
        end else if (r_state == S_DIV && div_done) begin
            ctl.wr_en = 1'b1;
            ctl.wr_data.countdown = (div_quot[DVD_W-1:32] != '0) ?
                                    32'hFFFF_FFFF : div_quot[31:0];
        end else if (r_state == S_STR && r_step == 2'd2) begin
            ctl.wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv <= 1'b0;
            r_div_start <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_DEC) && d_div;
            if (r_state == S_FIN && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_addr <= '0;
                        r_rv <= 1'b0;
                        r_state <= s_axis_tuser ? S_FIN : S_SRCH;
                    end
                end
                S_SRCH: begin
                    r_raddr <= r_addr;
                    r_rv <= 1'b1;
                    if (r_addr != LAST) begin
                        r_addr <= r_addr + AW'(1);
                    end
                    if (hit_now || (r_rv && r_raddr == LAST)) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: r_state <= S_DEC;
                S_DEC: begin
                    if (d_div) begin
                        r_state <= S_DIV;
                    end else if (d_str) begin
                        r_step <= '0;
                        r_state <= S_STR;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_STR: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd2) begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tid <= s_axis_tuser ? 8'd0 : s_axis_tdata[7:0];
            r_period <= s_axis_tdata[39:8];
            r_elapsed <= s_axis_tdata[71:40];
            r_resync <= s_axis_tdata[72];
            r_blocked <= s_axis_tdata[73];
            r_other <= s_axis_tdata[74];
            r_act <= ACT_NONE;
            r_newp <= '0;
            r_forced <= 1'b0;
            r_cnt <= '0;
            r_full <= 1'b0;
        end
        if (r_state == S_SRCH) begin
            if (hit_now) begin
                r_hit <= 1'b1;
                r_idx <= r_raddr;
                r_ent <= tbl_data;
            end else begin
                r_hit <= 1'b0;
            end
        end
        if (r_state == S_CALC) begin
            r_pa <= 40'(r_period) * 40'(g);
            r_pb <= 41'({8'd0, r_elapsed} + 40'd1) * 41'(gd);
            r_ps <= 42'(orig_sel) * 42'(r_safety[9:0]);
            r_psl <= 42'(r_period) * 42'(r_slip);
            r_tp100 <= 39'((r_tick == '0) ? 32'd1 : r_tick) * 39'(100);
            r_oq <= oq_prod[63:38];
        end
        if (r_state == S_DEC) begin
            r_act <= d_act;
            r_forced <= d_forced;
            r_cnt <= d_cnt;
            r_full <= d_full;
            r_went <= d_ent;
            r_widx <= d_widx;
            r_orem <= orem_full[6:0];
            r_oqs <= 36'(r_oq) * 36'(r_stretch);
        end
        if (r_state == S_STR) begin
            case (r_step)
                2'd0: r_rs <= 17'(r_orem) * 17'(r_stretch);
                2'd1: r_frac <= frac_prod[33:24];
                2'd2: r_newp <= (newp_sum[36:32] != '0) ? 32'hFFFF_FFFF : newp_sum[31:0];
                default: r_frac <= r_frac;
            endcase
        end
        if (r_state == S_FIN && (!r_ovalid || m_axis_tready)) begin
            r_odata <= {3'd0, r_full, r_cnt, r_forced, r_newp, r_act, r_tid};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/tom_table.sv
`default_nettype none
module tom_table #(
    parameter int ENTRIES = tom_pkg::TABLE_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tom_pkg::t_tbl_ctl i_ctl,
    output tom_pkg::t_entry        o_rd_data,
    output logic                   o_rd_used,
    output logic [tom_pkg::IDX_W-1:0] o_free_idx,
    output logic                   o_free_ok
);
    import tom_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_entry             mem [ENTRIES];
    t_entry             r_rd_data;
    logic               r_rd_used;
    logic [ENTRIES-1:0] r_used;
    logic [ENTRIES-1:0] r_seen;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_ctl.wr_addr[AW-1:0]] <= i_ctl.wr_data;
        end
        r_rd_data <= mem[i_ctl.rd_addr[AW-1:0]];
        r_rd_used <= r_used[i_ctl.rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_seen <= '0;
        end else if (i_ctl.purge) begin
            r_used <= r_used & r_seen;
            r_seen <= '0;
        end else begin
            if (i_ctl.seen_en) begin
                r_seen[i_ctl.seen_addr[AW-1:0]] <= 1'b1;
            end
            if (i_ctl.alloc_en) begin
                r_used[i_ctl.wr_addr[AW-1:0]] <= 1'b1;
                r_seen[i_ctl.wr_addr[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_comb begin
        o_free_idx = '0;
        o_free_ok = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                o_free_idx = IDX_W'(i);
                o_free_ok = 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_used = r_rd_used;
endmodule
`default_nettype wire

FILE: rtl/tom_div.sv
`default_nettype none
module tom_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [tom_pkg::DVD_W-1:0] i_dvd,
    input  wire logic [tom_pkg::DVS_W-1:0] i_dvs,
    output logic                           o_done,
    output logic [tom_pkg::DVD_W-1:0]      o_quot
);
    import tom_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_q;
    logic [DVS_W:0]    r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {r_rem[DVS_W-1:0], r_q[DVD_W-1]};
    assign ge = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= DCNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_q <= {r_q[DVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

FILE: rtl/tom_checker.sv
`default_nettype none
module tom_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);
    import tom_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one is in work");

    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:8] != 3'd7)
        else $error("undefined action code");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");
endmodule

bind task_overrun_policy_monitor tom_checker u_tom_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
